// ----- rtl/button_typematic_repeat_unit_macros.svh -----
// Assertion macros for the button typematic repeat unit.
// Included by the RTL files that carry concurrent checks; no other dependencies.
`ifndef BUTTON_TYPEMATIC_REPEAT_UNIT_MACROS_SVH
`define BUTTON_TYPEMATIC_REPEAT_UNIT_MACROS_SVH
`ifndef ASSERT_OFF
// Generic clocked check with explicit clock and reset
`define BTR_ASSERT_CLK(lbl, c, r, prop, msg) \
  lbl: assert property (@(posedge c) disable iff (r) prop) else $error(msg);
// Check on the local clk and rst
`define BTR_ASSERT(lbl, prop, msg) \
  `BTR_ASSERT_CLK(lbl, clk, rst, prop, msg)
`else
`define BTR_ASSERT_CLK(lbl, c, r, prop, msg)
`define BTR_ASSERT(lbl, prop, msg)
`endif
`endif

// ----- rtl/btr_pkg.sv -----
// Shared types, codes and constant tables for the button typematic repeat unit.
// No dependencies; imported by every module of the block.
package btr_pkg;

  localparam int BUTTON_W = 16;
  localparam int KEY_W    = 8;
  localparam int CNT_W    = 10;
  localparam int IDX_W    = 3;

  // Event codes
  localparam logic [1:0] MODE_TICK    = 2'd0;
  localparam logic [1:0] MODE_PRESS   = 2'd1;
  localparam logic [1:0] MODE_RELEASE = 2'd2;

  // Entry phases; the spare code behaves as idle
  localparam logic [1:0] PHASE_IDLE   = 2'd0;
  localparam logic [1:0] PHASE_DELAY  = 2'd1;
  localparam logic [1:0] PHASE_REPEAT = 2'd2;

  // Result kinds
  localparam logic KIND_KEY     = 1'b0;
  localparam logic KIND_VERDICT = 1'b1;

  // Register indexes
  localparam logic [IDX_W-1:0] REG_ENTRY0_BUTTON  = 3'd0;
  localparam logic [IDX_W-1:0] REG_ENTRY0_KEY     = 3'd1;
  localparam logic [IDX_W-1:0] REG_ENTRY1_BUTTON  = 3'd2;
  localparam logic [IDX_W-1:0] REG_ENTRY1_KEY     = 3'd3;
  localparam logic [IDX_W-1:0] REG_DELAY_SETTING  = 3'd4;
  localparam logic [IDX_W-1:0] REG_REPEAT_SETTING = 3'd5;

  // Repeat interval in ms: 400 - ceil(367*r/31)
  localparam logic [CNT_W-1:0] INTERVAL_TBL [32] = '{
    10'd400, 10'd388, 10'd376, 10'd364, 10'd352, 10'd340, 10'd328, 10'd317,
    10'd305, 10'd293, 10'd281, 10'd269, 10'd257, 10'd246, 10'd234, 10'd222,
    10'd210, 10'd198, 10'd186, 10'd175, 10'd163, 10'd151, 10'd139, 10'd127,
    10'd115, 10'd104, 10'd92,  10'd80,  10'd68,  10'd56,  10'd44,  10'd33
  };

  typedef enum logic [1:0] {
    S_IDLE,
    S_ENT0,
    S_ENT1,
    S_VERDICT
  } state_t;

  typedef struct packed {
    logic [BUTTON_W-1:0] button0;
    logic [KEY_W-1:0]    key0;
    logic [BUTTON_W-1:0] button1;
    logic [KEY_W-1:0]    key1;
    logic [1:0]          delay_setting;
    logic [4:0]          repeat_setting;
  } cfg_t;

  // Request to the shared step unit for the entry under service
  typedef struct packed {
    logic [1:0]       mode;
    logic [1:0]       phase;
    logic [CNT_W-1:0] count;
    logic             match;
    logic [CNT_W-1:0] delay_ld;
    logic [CNT_W-1:0] interval_ld;
  } unit_req_t;

  typedef struct packed {
    logic [1:0]       phase;
    logic [CNT_W-1:0] count;
    logic             emit;
  } unit_rsp_t;

  // Initial delay in ms: 250*(d+1)
  function automatic logic [CNT_W-1:0] delay_ms(input logic [1:0] d);
    logic [CNT_W-1:0] v;
    case (d)
      2'd0:    v = 10'd250;
      2'd1:    v = 10'd500;
      2'd2:    v = 10'd750;
      default: v = 10'd1000;
    endcase
    return v;
  endfunction

endpackage

// ----- rtl/button_typematic_repeat_unit.sv -----
// Top level of the button typematic repeat unit: register file and block wiring.
// Depends on btr_pkg, btr_ctrl and btr_step_unit.
//
//   channel  | handshake            | payload
//   ---------+----------------------+-----------------------------------
//   input    | in_valid / in_stall  | mode, button
//   result   | out_valid / out_stall| kind, key_code, consumed, last
//   config   | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// An event is taken in the idle state, then the shared step unit visits entry 0
// and then entry 1; a press or release adds the verdict state. A full, stalled
// output register holds the sequencer whenever it has a result to load.
// Reset clears both entries to idle and loads the register defaults at once.
// Config writes are always ready; ignored beyond the last register index.
module button_typematic_repeat_unit (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [1:0]                   mode,
  input  logic [btr_pkg::BUTTON_W-1:0] button,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         kind,
  output logic [btr_pkg::KEY_W-1:0]    key_code,
  output logic                         consumed,
  output logic                         last,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [btr_pkg::IDX_W-1:0]    cfg_index,
  input  logic [btr_pkg::BUTTON_W-1:0] cfg_data
);
  import btr_pkg::*;

  cfg_t      cfg;
  unit_req_t req;
  unit_rsp_t rsp;

  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.button0        <= 16'd1;
      cfg.key0           <= 8'd174;
      cfg.button1        <= 16'd2;
      cfg.key1           <= 8'd175;
      cfg.delay_setting  <= 2'd1;
      cfg.repeat_setting <= 5'd31;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_ENTRY0_BUTTON:  cfg.button0        <= cfg_data;
        REG_ENTRY0_KEY:     cfg.key0           <= cfg_data[KEY_W-1:0];
        REG_ENTRY1_BUTTON:  cfg.button1        <= cfg_data;
        REG_ENTRY1_KEY:     cfg.key1           <= cfg_data[KEY_W-1:0];
        REG_DELAY_SETTING:  cfg.delay_setting  <= cfg_data[1:0];
        REG_REPEAT_SETTING: cfg.repeat_setting <= cfg_data[4:0];
        default: begin
        end
      endcase
    end
  end

  btr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .mode      (mode),
    .button    (button),
    .cfg       (cfg),
    .req       (req),
    .rsp       (rsp),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .kind      (kind),
    .key_code  (key_code),
    .consumed  (consumed),
    .last      (last)
  );

  btr_step_unit u_step (
    .req (req),
    .rsp (rsp)
  );

endmodule

// ----- rtl/btr_step_unit.sv -----
// Shared entry step unit: phase and countdown update of one mapping entry.
// Depends on btr_pkg.
module btr_step_unit (
  input  btr_pkg::unit_req_t req,
  output btr_pkg::unit_rsp_t rsp
);
  import btr_pkg::*;

  logic active;

  assign active = (req.phase == PHASE_DELAY) || (req.phase == PHASE_REPEAT);

  // One step of the selected entry for the current event
  always_comb begin
    rsp.phase = req.phase;
    rsp.count = req.count;
    rsp.emit  = 1'b0;
    case (req.mode)
      MODE_TICK: begin
        if (active) begin
          if (req.count > 10'd1) begin
            rsp.count = req.count - 10'd1;
          end else begin
            rsp.count = req.interval_ld;
            if (req.phase == PHASE_DELAY) begin
              rsp.phase = PHASE_REPEAT;
            end else begin
              rsp.emit = 1'b1;
            end
          end
        end
      end
      MODE_PRESS: begin
        if (req.match && !active) begin
          rsp.phase = PHASE_DELAY;
          rsp.count = req.delay_ld;
          rsp.emit  = 1'b1;
        end
      end
      MODE_RELEASE: begin
        if (req.match) begin
          rsp.phase = PHASE_IDLE;
          rsp.count = '0;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// ----- rtl/btr_ctrl.sv -----
// Sequencer, entry state and output register of the typematic repeat unit.
// Depends on btr_pkg and the assertion macro header.
`include "button_typematic_repeat_unit_macros.svh"
module btr_ctrl (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    mode,
  input  logic [btr_pkg::BUTTON_W-1:0]  button,
  input  btr_pkg::cfg_t                 cfg,
  output btr_pkg::unit_req_t            req,
  input  btr_pkg::unit_rsp_t            rsp,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          kind,
  output logic [btr_pkg::KEY_W-1:0]     key_code,
  output logic                          consumed,
  output logic                          last
);
  import btr_pkg::*;

  state_t              state, state_next;
  logic [1:0]          mode_q;
  logic [BUTTON_W-1:0] button_q;
  logic                hit;
  logic [1:0]          phase [2];
  logic [CNT_W-1:0]    count [2];

  logic sel;
  logic out_free;
  logic step_go;
  logic load_key;
  logic load_verdict;
  logic ent1_due;
  logic key_last;
  logic accept;

  assign sel      = (state == S_ENT1);
  assign out_free = !out_valid || !out_stall;
  assign accept   = in_valid && !in_stall;

  // Request for the entry under service
  always_comb begin
    req.mode        = mode_q;
    req.phase       = phase[sel];
    req.count       = count[sel];
    req.match       = (button_q == (sel ? cfg.button1 : cfg.button0));
    req.delay_ld    = delay_ms(cfg.delay_setting);
    req.interval_ld = INTERVAL_TBL[cfg.repeat_setting];
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid && (mode == MODE_TICK || mode == MODE_PRESS || mode == MODE_RELEASE))
          state_next = S_ENT0;
      end
      S_ENT0: begin
        if (step_go) state_next = S_ENT1;
      end
      S_ENT1: begin
        if (step_go) state_next = (mode_q == MODE_TICK) ? S_IDLE : S_VERDICT;
      end
      S_VERDICT: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    in_stall     = (state != S_IDLE);
    step_go      = ((state == S_ENT0) || (state == S_ENT1)) && (!rsp.emit || out_free);
    load_key     = step_go && rsp.emit;
    load_verdict = (state == S_VERDICT) && out_free;
    // entry 1 fires a key on this tick: entry 0's key is then not the last
    ent1_due     = (phase[1] == PHASE_REPEAT) && (count[1] <= 10'd1);
    key_last     = (mode_q == MODE_TICK) && (sel || !ent1_due);
  end

  // Control registers and entry state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      hit       <= 1'b0;
      phase[0]  <= PHASE_IDLE;
      phase[1]  <= PHASE_IDLE;
      count[0]  <= '0;
      count[1]  <= '0;
    end else begin
      state <= state_next;
      if (load_key || load_verdict) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (accept) begin
        hit <= 1'b0;
      end else if (step_go) begin
        hit <= hit | req.match;
      end
      if (step_go) begin
        phase[sel] <= rsp.phase;
        count[sel] <= rsp.count;
      end
    end
  end

  // Captured event and result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      mode_q   <= mode;
      button_q <= button;
    end
    if (load_key) begin
      kind     <= KIND_KEY;
      key_code <= sel ? cfg.key1 : cfg.key0;
      consumed <= 1'b0;
      last     <= key_last;
    end else if (load_verdict) begin
      kind     <= KIND_VERDICT;
      key_code <= '0;
      consumed <= hit;
      last     <= 1'b1;
    end
  end

  `BTR_ASSERT(a_accept_starts, accept && (mode == MODE_TICK || mode == MODE_PRESS || mode == MODE_RELEASE) |=> state == S_ENT0, "accepted event did not start the entry walk")
  `BTR_ASSERT(a_ent0_order, state == S_ENT0 |=> state == S_ENT0 || state == S_ENT1, "entry 0 not followed by entry 1")
  `BTR_ASSERT(a_verdict_out, load_verdict |=> out_valid && kind == KIND_VERDICT && last, "verdict not presented as final result")
  `BTR_ASSERT(a_press_key_not_last, load_key && mode_q != MODE_TICK |=> out_valid && kind == KIND_KEY && !last, "press key marked as final result")

endmodule

// ----- verif/button_typematic_repeat_unit_test.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for button_typematic_repeat_unit: drives ticks, button
// events and register writes, and predicts every key and verdict transaction.
// Depends on btr_pkg and the button_typematic_repeat_unit RTL only.
module button_typematic_repeat_unit_test;
  import btr_pkg::*;

  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int SETTLE_CYCLES  = 8;
  localparam int HOLD_CYCLES    = 160;
  localparam int WATCHDOG_LIMIT = 2500;
  localparam int MAX_REPORTS    = 10;

  typedef struct packed {
    logic             kind;
    logic [KEY_W-1:0] key_code;
    logic             consumed;
    logic             last;
  } key_result_t;

  // Clock and block ports
  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [1:0]          mode = MODE_TICK;
  logic [BUTTON_W-1:0] button = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic                kind;
  logic [KEY_W-1:0]    key_code;
  logic                consumed;
  logic                last;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [IDX_W-1:0]    cfg_index = REG_ENTRY0_BUTTON;
  logic [BUTTON_W-1:0] cfg_data = '0;

  // Predicted register contents and per-slot repeat state
  logic [BUTTON_W-1:0] map_button [2] = '{16'd1, 16'd2};
  logic [KEY_W-1:0]    map_key [2] = '{8'd174, 8'd175};
  logic [1:0]          delay_step = 2'd1;
  logic [4:0]          speed_step = 5'd31;
  logic [1:0]          slot_state [2] = '{PHASE_IDLE, PHASE_IDLE};
  logic [CNT_W-1:0]    slot_timer [2] = '{10'd0, 10'd0};

  key_result_t pending_results[$];
  key_result_t got_result;
  key_result_t want_result;
  int          mismatches = 0;
  int          idle_cycles = 0;
  int          burst_left = 0;

  // Receiver stall control
  logic hold_req = 1'b0;
  logic calm = 1'b0;
  int   hold_left = 0;
  int   stall_left = 0;
  int   segment_left = 0;

  always #10 clk = ~clk;

  button_typematic_repeat_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .mode      (mode),
    .button    (button),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .kind      (kind),
    .key_code  (key_code),
    .consumed  (consumed),
    .last      (last),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Initial delay: 250 ms per step, first step included
  function automatic logic [CNT_W-1:0] hold_off_ms();
    return CNT_W'(250 * (int'(delay_step) + 1));
  endfunction

  // Repeat interval: 400 ms minus 367/31 ms per step, rounded to keep it whole
  function automatic logic [CNT_W-1:0] repeat_period_ms();
    return CNT_W'(400 - (367 * int'(speed_step) + 30) / 31);
  endfunction

  // Works out the key and verdict transactions one accepted event causes
  function automatic void predict_typematic(input logic [1:0] m,
                                            input logic [BUTTON_W-1:0] b);
    key_result_t burst[$];
    logic        hit;
    hit = 1'b0;
    if (m == MODE_TICK) begin
      for (int i = 0; i < 2; i++) begin
        if (slot_state[i] == PHASE_DELAY || slot_state[i] == PHASE_REPEAT) begin
          if (slot_timer[i] > 1) begin
            slot_timer[i] = slot_timer[i] - 1'b1;
          end else begin
            slot_timer[i] = repeat_period_ms();
            if (slot_state[i] == PHASE_DELAY) begin
              slot_state[i] = PHASE_REPEAT;
            end else begin
              burst.push_back(key_result_t'{KIND_KEY, map_key[i], 1'b0, 1'b0});
            end
          end
        end
      end
    end else if (m == MODE_PRESS || m == MODE_RELEASE) begin
      for (int i = 0; i < 2; i++) begin
        if (map_button[i] == b) begin
          hit = 1'b1;
          if (m == MODE_RELEASE) begin
            slot_state[i] = PHASE_IDLE;
            slot_timer[i] = '0;
          end else if (slot_state[i] != PHASE_DELAY && slot_state[i] != PHASE_REPEAT) begin
            slot_state[i] = PHASE_DELAY;
            slot_timer[i] = hold_off_ms();
            burst.push_back(key_result_t'{KIND_KEY, map_key[i], 1'b0, 1'b0});
          end
        end
      end
      burst.push_back(key_result_t'{KIND_VERDICT, {KEY_W{1'b0}}, hit, 1'b0});
    end
    if (burst.size() > 0) burst[burst.size() - 1].last = 1'b1;
    foreach (burst[j]) pending_results.push_back(burst[j]);
  endfunction

  function automatic void apply_register(input logic [IDX_W-1:0] idx,
                                         input logic [BUTTON_W-1:0] data);
    case (idx)
      REG_ENTRY0_BUTTON:  map_button[0] = data;
      REG_ENTRY0_KEY:     map_key[0] = data[KEY_W-1:0];
      REG_ENTRY1_BUTTON:  map_button[1] = data;
      REG_ENTRY1_KEY:     map_key[1] = data[KEY_W-1:0];
      REG_DELAY_SETTING:  delay_step = data[1:0];
      REG_REPEAT_SETTING: speed_step = data[4:0];
      default: ;
    endcase
  endfunction

  // Sender idle gaps: mostly none or short, a few long, now and then a burst
  function automatic int sender_gap();
    int pick;
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    pick = $urandom_range(0, 99);
    if (pick < 3) begin
      burst_left = $urandom_range(20, 80);
      return 0;
    end
    if (pick < 55) return 0;
    if (pick < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // One input transaction; valid stays high only when another follows at once
  task automatic send_event(input logic [1:0] m, input logic [BUTTON_W-1:0] b,
                            input bit keep_going);
    int gap;
    mode     <= m;
    button   <= b;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    predict_typematic(m, b);
    gap = keep_going ? 0 : sender_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic run_ticks(input int count);
    for (int i = 0; i < count; i++) send_event(MODE_TICK, BUTTON_W'($urandom), 1'b0);
  endtask

  // Stop sending and let every expected transaction arrive, then settle
  task automatic wait_for_drain();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [BUTTON_W-1:0] data,
                           input bit more);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    apply_register(idx, data);
    if (!more) cfg_valid <= 1'b0;
  endtask

  // Writes all six registers; with dirty set the unused upper bits carry junk
  task automatic set_config(input logic [BUTTON_W-1:0] b0, input logic [KEY_W-1:0] k0,
                            input logic [BUTTON_W-1:0] b1, input logic [KEY_W-1:0] k1,
                            input logic [1:0] d, input logic [4:0] r, input bit dirty);
    logic [BUTTON_W-1:0] junk;
    junk = dirty ? BUTTON_W'($urandom) : '0;
    write_reg(REG_ENTRY0_BUTTON, b0, 1'b1);
    write_reg(REG_ENTRY0_KEY, {junk[15:8], k0}, 1'b1);
    write_reg(REG_ENTRY1_BUTTON, b1, 1'b1);
    write_reg(REG_ENTRY1_KEY, {junk[7:0], k1}, 1'b1);
    write_reg(REG_DELAY_SETTING, {junk[13:0], d}, 1'b1);
    write_reg(REG_REPEAT_SETTING, {junk[10:0], r}, 1'b0);
  endtask

  // Unmapped, busy, ignored and idle-release cases under the reset mapping
  task automatic test_directed_events();
    send_event(MODE_TICK, 16'hFFFF, 1'b0);
    send_event(MODE_UNUSED, 16'd1, 1'b0);
    send_event(MODE_PRESS, 16'hFFFF, 1'b0);
    send_event(MODE_RELEASE, 16'h0000, 1'b0);
    send_event(MODE_PRESS, 16'd1, 1'b0);
    send_event(MODE_PRESS, 16'd1, 1'b0);
    send_event(MODE_PRESS, 16'd2, 1'b0);
    send_event(MODE_UNUSED, 16'd2, 1'b0);
    run_ticks(3);
    send_event(MODE_RELEASE, 16'd2, 1'b0);
    send_event(MODE_RELEASE, 16'd2, 1'b0);
    send_event(MODE_PRESS, 16'h8000, 1'b0);
    send_event(MODE_RELEASE, 16'h7FFE, 1'b0);
    send_event(MODE_RELEASE, 16'd1, 1'b0);
    send_event(MODE_TICK, 16'h0000, 1'b0);
    wait_for_drain();
  endtask

  // Shortest delay and interval with extreme buttons and key codes: both slots
  // repeat on one tick, then the first slot alone
  task automatic test_extreme_settings();
    set_config(16'h0000, 8'h00, 16'hFFFF, 8'hFF, 2'd0, 5'd31, 1'b1);
    send_event(MODE_PRESS, 16'h0000, 1'b0);
    send_event(MODE_PRESS, 16'hFFFF, 1'b0);
    run_ticks(int'(hold_off_ms()) + int'(repeat_period_ms()) + 1);
    send_event(MODE_RELEASE, 16'hFFFF, 1'b0);
    run_ticks(int'(repeat_period_ms()));
    send_event(MODE_RELEASE, 16'h0000, 1'b0);
    wait_for_drain();
  endtask

  // Both slots on one button: two keys per press, busy press, release
  task automatic test_shared_button();
    set_config(16'h1234, 8'h10, 16'h1234, 8'h20, 2'd3, 5'd0, 1'b1);
    send_event(MODE_PRESS, 16'h1234, 1'b0);
    run_ticks(4);
    send_event(MODE_PRESS, 16'h1234, 1'b0);
    send_event(MODE_RELEASE, 16'h1234, 1'b0);
    run_ticks(2);
    send_event(MODE_PRESS, 16'h1234, 1'b0);
    send_event(MODE_RELEASE, 16'h1234, 1'b0);
    wait_for_drain();
  endtask

  // Receiver holds off for a long stretch while events arrive back to back
  task automatic test_output_backpressure();
    set_config(16'd3, 8'd33, 16'd4, 8'd44, 2'd0, 5'd31, 1'b0);
    hold_req = 1'b1;
    for (int i = 0; i < 16; i++) begin
      send_event(i[0] ? MODE_RELEASE : MODE_PRESS, map_button[i[1]], 1'b1);
    end
    wait_for_drain();
  endtask

  // Receiver stall pattern: calm and busy stretches, plus requested long holds
  always @(posedge clk) begin
    if (segment_left == 0) begin
      calm = ($urandom_range(0, 3) == 0);
      segment_left = $urandom_range(20, 200);
    end else begin
      segment_left--;
    end
    if (hold_req) begin
      hold_req = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (!calm && $urandom_range(0, 99) < 25) begin
      stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Compare each output transaction with the oldest prediction
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      got_result = key_result_t'{kind, key_code, consumed, last};
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("unexpected transaction: kind=%0d key_code=%0d consumed=%0d last=%0d",
                   got_result.kind, got_result.key_code, got_result.consumed,
                   got_result.last);
        end
      end else begin
        want_result = pending_results.pop_front();
        if (got_result.kind !== want_result.kind ||
            got_result.key_code !== want_result.key_code ||
            got_result.consumed !== want_result.consumed ||
            got_result.last !== want_result.last) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display("mismatch: expected kind=%0d key_code=%0d consumed=%0d last=%0d",
                     want_result.kind, want_result.key_code, want_result.consumed,
                     want_result.last);
            $display("          actual   kind=%0d key_code=%0d consumed=%0d last=%0d",
                     got_result.kind, got_result.key_code, got_result.consumed,
                     got_result.last);
          end
        end
      end
    end
  end

  // Watchdog: too long without any accepted transaction ends the run
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    test_directed_events();
    test_extreme_settings();
    test_shared_button();
    test_output_backpressure();
    wait_for_drain();
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
